>>> sv/cts_pkg.sv
// Shared constants and types of the cache tag store.
package cts_pkg;

  localparam int ADDR_W    = 32;
  localparam int RND_W     = 10;
  localparam int ETAG_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam int LL_CAP    = 10;

  localparam logic [3:0] LL_LO   = 4'd2;
  localparam logic [3:0] OFFS_HI = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_ORG    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINES  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 4'd3;

  localparam logic [1:0] ORG_DIRECT = 2'd0;
  localparam logic [1:0] ORG_FOUR   = 2'd1;
  localparam logic [1:0] ORG_FULL   = 2'd2;
  localparam logic [1:0] ORG_ALT    = 2'd3;

  localparam logic [1:0] POL_FIFO   = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [1:0] POL_ALT    = 2'd3;

  typedef struct packed {
    logic hit;
    logic fill;
    logic lower;
  } cmp_res_t;

endpackage

>>> sv/cts_if.sv
// Request, response and configuration channel interfaces.
interface cts_req_if;
  logic                       valid;
  logic                       ready;
  logic [cts_pkg::ADDR_W-1:0] address;
  logic [cts_pkg::RND_W-1:0]  random_way;
  modport source (output valid, address, random_way, input ready);
  modport sink (input valid, address, random_way, output ready);
endinterface

interface cts_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       replaced;
  logic [cts_pkg::ETAG_W-1:0] evicted_tag;
  modport source (output valid, replaced, evicted_tag, input ready);
  modport sink (input valid, replaced, evicted_tag, output ready);
endinterface

interface cts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cts_pkg::CFG_IDX_W-1:0] index;
  logic [cts_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/cts_ram.sv
// Generic simple dual-port RAM with registered read.
module cts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cts_geom.sv
// Address split into set index and tag under the configured geometry.
module cts_geom #(
  parameter int LL_MAX = 10,
  parameter int TAG_W  = 32
) (
  input  logic [1:0]                 org_i,
  input  logic [1:0]                 pol_i,
  input  logic [3:0]                 lines_log2_i,
  input  logic [3:0]                 offset_bits_i,
  input  logic [cts_pkg::ADDR_W-1:0] address_i,
  output logic [3:0]                 ways_log2_o,
  output logic [1:0]                 pol_o,
  output logic [LL_MAX-1:0]          set_o,
  output logic [TAG_W-1:0]           tag_o
);
  import cts_pkg::*;

  localparam logic [3:0] LL_HI = 4'(LL_MAX);

  logic [3:0]        ll;
  logic [3:0]        ob;
  logic [3:0]        set_bits;
  logic [4:0]        tag_sh;
  logic [TAG_W-1:0]  addr_m;
  logic [TAG_W-1:0]  addr_sh;
  logic [LL_MAX-1:0] set_mask;

  always_comb begin
    priority if (lines_log2_i < LL_LO) begin
      ll = LL_LO;
    end else if (lines_log2_i > LL_HI) begin
      ll = LL_HI;
    end else begin
      ll = lines_log2_i;
    end
    ob = (offset_bits_i > OFFS_HI) ? OFFS_HI : offset_bits_i;
    unique case (org_i)
      ORG_DIRECT: ways_log2_o = 4'd0;
      ORG_FOUR:   ways_log2_o = 4'd2;
      default:    ways_log2_o = ll;
    endcase
    pol_o    = (pol_i == POL_ALT) ? POL_RANDOM : pol_i;
    set_bits = ll - ways_log2_o;
    addr_m   = address_i[TAG_W-1:0];
    addr_sh  = addr_m >> ob;
    set_mask = ~({LL_MAX{1'b1}} << set_bits);
    set_o    = addr_sh[LL_MAX-1:0] & set_mask;
    tag_sh   = 5'(ob) + 5'(set_bits);
    tag_o    = addr_m >> tag_sh;
  end

endmodule

>>> sv/cts_wcmp.sv
// Shared way compare unit: tag match, free way and running stamp minimum.
module cts_wcmp #(
  parameter int TAG_W = 32,
  parameter int WAY_W = 10
) (
  input  logic                        clk_i,
  input  logic                        chk_i,
  input  logic [WAY_W-1:0]            way_i,
  input  logic                        line_vld_i,
  input  logic [TAG_W-1:0]            line_tag_i,
  input  logic [TAG_W-1:0]            key_i,
  input  logic [cts_pkg::STAMP_W-1:0] stamp_i,
  output cts_pkg::cmp_res_t           res_o,
  output logic [WAY_W-1:0]            lru_way_o
);
  import cts_pkg::*;

  logic [STAMP_W-1:0] min_stamp_q;
  logic [WAY_W-1:0]   min_way_q;

  always_comb begin
    res_o.hit   = line_vld_i && (line_tag_i == key_i);
    res_o.fill  = !line_vld_i;
    res_o.lower = (way_i == '0) || (stamp_i < min_stamp_q);
    lru_way_o   = res_o.lower ? way_i : min_way_q;
  end

  always_ff @(posedge clk_i) begin
    if (chk_i && res_o.lower) begin
      min_stamp_q <= stamp_i;
      min_way_q   <= way_i;
    end
  end

endmodule

>>> sv/cache_tag_store_replacement.sv
// Cache tag store with direct mapped, 4-way or fully associative lookup.
// One item at a time: a hit or fill ends the scan at the way where it is found; a
// replacement scans all ways, up to 2^min(10,log2 MAX_LINES), and reads the victim tag.
// The ways of the set are read one per cycle through the line and tag memory read port.
// After reset a clearing pass over 2^min(10,log2 MAX_LINES) entries zeroes the line and
// set memories; no item is taken before it ends, configuration writes are always taken.
module cache_tag_store_replacement #(
  parameter int MAX_LINES    = 1024,
  parameter int ADDRESS_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cts_req_if.sink   req_i,
  cts_rsp_if.source rsp_o,
  cts_cfg_if.sink   cfg_i
);
  import cts_pkg::*;

  localparam int LG_MAX = $clog2(MAX_LINES + 1) - 1;
  localparam int LL_MAX = (LG_MAX > LL_CAP) ? LL_CAP : LG_MAX;
  localparam int NLINES = 1 << LL_MAX;
  localparam int WAY_W  = LL_MAX;
  localparam int CNT_W  = LL_MAX + 1;
  localparam int TAG_W  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int LINE_W = 1 + STAMP_W;
  localparam int SET_W  = STAMP_W + WAY_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_EVRD, S_EVCAP, S_UPD} state_e;

  state_e             state_q;
  logic [1:0]         org_q, pol_cfg_q;
  logic [3:0]         ll_q, ob_q;
  logic [WAY_W-1:0]   clr_q;
  logic [CNT_W-1:0]   rd_way_q;
  logic               chk_vld_q;
  logic               rsp_valid_q;

  logic [WAY_W-1:0]   chk_way_q, tgt_q, set_q, base_q, mask_q;
  logic [CNT_W-1:0]   ways_q;
  logic [3:0]         wl_q;
  logic [1:0]         pol_q;
  logic [TAG_W-1:0]   tag_q, evict_q;
  logic [RND_W-1:0]   rnd_q;
  logic               repl_q;
  logic               replaced_q;
  logic [ETAG_W-1:0]  evicted_q;

  logic [3:0]         g_wl;
  logic [1:0]         g_pol;
  logic [WAY_W-1:0]   g_set;
  logic [TAG_W-1:0]   g_tag;
  logic [CNT_W-1:0]   g_ways;

  logic               req_xfer, issue, clearing, upd_go, decide, exhaust;
  logic [WAY_W-1:0]   victim, lru_way, fifo_ptr, fifo_new, rd_addr;
  logic [STAMP_W-1:0] set_cnt, next_stamp;
  cmp_res_t           cmp_res;

  logic               line_we, tag_we, set_we;
  logic [WAY_W-1:0]   line_waddr, set_waddr;
  logic [LINE_W-1:0]  line_wdata, line_rdata;
  logic [SET_W-1:0]   set_wdata, set_rdata;
  logic [TAG_W-1:0]   tag_rdata;

  cts_geom #(.LL_MAX(LL_MAX), .TAG_W(TAG_W)) u_geom (
    .org_i         (org_q),
    .pol_i         (pol_cfg_q),
    .lines_log2_i  (ll_q),
    .offset_bits_i (ob_q),
    .address_i     (req_i.address),
    .ways_log2_o   (g_wl),
    .pol_o         (g_pol),
    .set_o         (g_set),
    .tag_o         (g_tag)
  );

  cts_wcmp #(.TAG_W(TAG_W), .WAY_W(WAY_W)) u_wcmp (
    .clk_i      (clk_i),
    .chk_i      (state_q == S_SCAN && chk_vld_q),
    .way_i      (chk_way_q),
    .line_vld_i (line_rdata[LINE_W-1]),
    .line_tag_i (tag_rdata),
    .key_i      (tag_q),
    .stamp_i    (line_rdata[STAMP_W-1:0]),
    .res_o      (cmp_res),
    .lru_way_o  (lru_way)
  );

  cts_ram #(.WIDTH(LINE_W), .DEPTH(NLINES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (rd_addr),
    .rdata_o (line_rdata)
  );

  cts_ram #(.WIDTH(TAG_W), .DEPTH(NLINES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (base_q | tgt_q),
    .wdata_i (tag_q),
    .raddr_i (rd_addr),
    .rdata_o (tag_rdata)
  );

  cts_ram #(.WIDTH(SET_W), .DEPTH(NLINES)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (set_waddr),
    .wdata_i (set_wdata),
    .raddr_i (set_q),
    .rdata_o (set_rdata)
  );

  assign cfg_i.ready     = 1'b1;
  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.replaced  = replaced_q;
  assign rsp_o.evicted_tag = evicted_q;

  always_comb begin
    req_xfer   = req_i.valid && (state_q == S_IDLE);
    g_ways     = CNT_W'(1) << g_wl;
    clearing   = (state_q == S_CLEAR);
    issue      = (state_q == S_SCAN) && (rd_way_q < ways_q);
    decide     = (state_q == S_SCAN) && chk_vld_q && (cmp_res.hit || cmp_res.fill);
    exhaust    = (state_q == S_SCAN) && chk_vld_q && !(cmp_res.hit || cmp_res.fill) &&
                 (chk_way_q == mask_q);
    upd_go     = (state_q == S_UPD) && (!rsp_valid_q || rsp_o.ready);
    rd_addr    = (state_q == S_EVRD) ? (base_q | tgt_q) : (base_q | rd_way_q[WAY_W-1:0]);
    fifo_ptr   = set_rdata[WAY_W-1:0];
    set_cnt    = set_rdata[SET_W-1:WAY_W];
    next_stamp = (&set_cnt) ? set_cnt : set_cnt + STAMP_W'(1);
    unique case (pol_q)
      POL_FIFO: victim = fifo_ptr & mask_q;
      POL_LRU:  victim = lru_way;
      default:  victim = rnd_q[WAY_W-1:0] & mask_q;
    endcase
    fifo_new   = (repl_q && pol_q == POL_FIFO && wl_q != 4'd0) ?
                 ((tgt_q + WAY_W'(1)) & mask_q) : fifo_ptr;
    line_we    = clearing || upd_go;
    line_waddr = clearing ? clr_q : (base_q | tgt_q);
    line_wdata = clearing ? '0 : {1'b1, next_stamp};
    tag_we     = upd_go;
    set_we     = clearing || upd_go;
    set_waddr  = clearing ? clr_q : set_q;
    set_wdata  = clearing ? '0 : {next_stamp, fifo_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q     <= ORG_DIRECT;
      pol_cfg_q <= POL_FIFO;
      ll_q      <= 4'd10;
      ob_q      <= 4'd4;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ORG:    org_q     <= cfg_i.data[1:0];
        REG_POLICY: pol_cfg_q <= cfg_i.data[1:0];
        REG_LINES:  ll_q      <= cfg_i.data[3:0];
        REG_OFFSET: ob_q      <= cfg_i.data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rd_way_q    <= '0;
      chk_vld_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (upd_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + WAY_W'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_xfer) begin
            state_q   <= S_SCAN;
            rd_way_q  <= '0;
            chk_vld_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_way_q <= rd_way_q + CNT_W'(1);
          end
          chk_vld_q <= issue;
          if (decide) begin
            state_q <= S_UPD;
          end else if (exhaust) begin
            state_q <= S_EVRD;
          end
        end
        S_EVRD:  state_q <= S_EVCAP;
        S_EVCAP: state_q <= S_UPD;
        S_UPD: begin
          if (upd_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      wl_q   <= g_wl;
      ways_q <= g_ways;
      mask_q <= WAY_W'(g_ways - CNT_W'(1));
      pol_q  <= g_pol;
      set_q  <= g_set;
      base_q <= g_set << g_wl;
      tag_q  <= g_tag;
      rnd_q  <= req_i.random_way;
    end
    if (state_q == S_SCAN) begin
      chk_way_q <= rd_way_q[WAY_W-1:0];
    end
    if (decide) begin
      tgt_q  <= chk_way_q;
      repl_q <= 1'b0;
    end else if (exhaust) begin
      tgt_q  <= victim;
      repl_q <= 1'b1;
    end
    if (state_q == S_EVCAP) begin
      evict_q <= tag_rdata;
    end
    if (upd_go) begin
      replaced_q <= repl_q;
      evicted_q  <= repl_q ? ETAG_W'(evict_q) : '0;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_way_q <= ways_q))
    else $error("way read counter passed the set size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.replaced) |-> (rsp_o.evicted_tag == '0))
    else $error("evicted tag nonzero without a replacement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a set scan");
`endif

endmodule

>>> tb/cache_tag_store_replacement_test.sv
// Self-checking testbench of the cache tag store: directed table, then random phases.
module cache_tag_store_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int          LINE_CNT    = 1024;
  localparam int          PHASES      = 14;
  localparam int          BIG_PHASE   = 9;
  localparam int          CALM_PHASE  = 4;
  localparam int          SETTLE      = 1100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DAT_W-1:0]  data;
    logic [ADDR_W-1:0]     addr;
    logic [RND_W-1:0]      rway;
    logic                  typed;
    logic                  repl;
    logic [ETAG_W-1:0]     etag;
  } step_t;

  typedef struct packed {
    logic              repl;
    logic [ETAG_W-1:0] etag;
  } lookup_t;

  localparam int DIR_LEN = 34;

  step_t directed_steps [DIR_LEN] = '{
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0000, 10'd0, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0000, 10'd1023, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_4000, 10'd0, 1'b1, 1'b1, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'hFFFF_FFF0, 10'd0, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0003_FFF0, 10'd0, 1'b1, 1'b1, 32'h0003_FFFF},
    '{ROW_REG, REG_OFFSET, 8'h00, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_LINES, 8'h02, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_ORG, {6'b0, ORG_FOUR}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0005, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0006, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0007, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0008, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0009, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_POLICY, {6'b0, POL_LRU}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_0006, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_000A, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_POLICY, {6'b0, POL_RANDOM}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_000B, 10'd1023, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_000C, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_POLICY, {6'b0, POL_ALT}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h0000_000D, 10'h2AA, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_ORG, {6'b0, ORG_FULL}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_LINES, 8'h50, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'hFFFF_FFFF, 10'd1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h8000_0000, 10'd3, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_ORG, {6'b0, ORG_ALT}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h7FFF_FFFF, 10'h155, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_OFFSET, 8'hAF, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_LINES, 8'h0F, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_ORG, {6'b0, ORG_DIRECT}, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'hFFFF_F000, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, REG_ORG, 8'h00, 32'h8000_0000, 10'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, REG_UNUSED, 8'h3C, 32'h0, 10'd0, 1'b0, 1'b0, 32'h0}
  };

  logic clk_i;
  logic rst_ni;

  cts_req_if req_if ();
  cts_rsp_if rsp_if ();
  cts_cfg_if cfg_if ();

  cache_tag_store_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // tag store image
  logic [1:0]         org_q   = ORG_DIRECT;
  logic [1:0]         pol_q   = POL_FIFO;
  logic [3:0]         lines_q = 4'd10;
  logic [3:0]         offs_q  = 4'd4;
  logic               line_valid [LINE_CNT];
  logic [ADDR_W-1:0]  line_tag   [LINE_CNT];
  logic [STAMP_W-1:0] line_stamp [LINE_CNT];
  logic [STAMP_W-1:0] set_count  [LINE_CNT];
  logic [RND_W-1:0]   fifo_ptr   [LINE_CNT];

  lookup_t            lookup_q [$];
  int                 error_count = 0;
  int unsigned        cycle_count = 0;
  int                 idle_pct    = 36;

  logic               item_typed;
  logic               item_repl;
  logic [ETAG_W-1:0]  item_etag;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("cache_tag_store_replacement test failed");
    $finish;
  end

  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);

  function automatic void decode_geometry(output int unsigned ob, output int unsigned sb,
                                          output int unsigned wl);
    int unsigned ll;
    ll = 32'(lines_q);
    if (ll < 32'(LL_LO)) ll = 32'(LL_LO);
    if (ll > LL_CAP) ll = LL_CAP;
    ob = (offs_q > OFFS_HI) ? 32'(OFFS_HI) : 32'(offs_q);
    if (org_q == ORG_DIRECT) wl = 0;
    else if (org_q == ORG_FOUR) wl = 2;
    else wl = ll;
    sb = ll - wl;
  endfunction

  function automatic logic [STAMP_W-1:0] bump_set_count(int unsigned s);
    if (set_count[s] != '1) set_count[s] = set_count[s] + 1'b1;
    return set_count[s];
  endfunction

  function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] addr, logic [RND_W-1:0] rway);
    lookup_t           r;
    int unsigned       ob, sb, wl, ways, s, base, victim, l, w;
    logic [ADDR_W-1:0] tag;
    bit                done;
    decode_geometry(ob, sb, wl);
    ways = 1 << wl;
    s    = (addr >> ob) & ((1 << sb) - 1);
    tag  = addr >> (ob + sb);
    base = s * ways;
    r    = '0;
    done = 1'b0;
    for (w = 0; w < ways && !done; w++) begin
      l = base + w;
      if (line_valid[l] && line_tag[l] == tag) begin
        line_stamp[l] = bump_set_count(s);
        done = 1'b1;
      end else if (!line_valid[l]) begin
        line_valid[l] = 1'b1;
        line_tag[l]   = tag;
        line_stamp[l] = bump_set_count(s);
        done = 1'b1;
      end
    end
    if (!done) begin
      victim = 0;
      if (ways > 1) begin
        if (pol_q == POL_FIFO) begin
          victim      = fifo_ptr[s] & (ways - 1);
          fifo_ptr[s] = RND_W'((victim + 1) & (ways - 1));
        end else if (pol_q == POL_LRU) begin
          for (w = 1; w < ways; w++)
            if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
        end else begin
          victim = rway & (ways - 1);
        end
      end
      r.repl = 1'b1;
      r.etag = line_tag[base + victim];
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = bump_set_count(s);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_ORG:    org_q   = cfg_if.data[1:0];
          REG_POLICY: pol_q   = cfg_if.data[1:0];
          REG_LINES:  lines_q = cfg_if.data[3:0];
          REG_OFFSET: offs_q  = cfg_if.data[3:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        want = predict_lookup(req_if.address, req_if.random_way);
        if (item_typed) want = '{item_repl, item_etag};
        lookup_q.push_back(want);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (lookup_q.size() == 0) begin
          $error("result transfer with nothing outstanding: replaced %0d evicted_tag %0h",
                 rsp_if.replaced, rsp_if.evicted_tag);
          error_count++;
        end else begin
          want = lookup_q.pop_front();
          if (rsp_if.replaced !== want.repl) begin
            $error("replaced: expected %0d, actual %0d", want.repl, rsp_if.replaced);
            error_count++;
          end
          if (rsp_if.evicted_tag !== want.etag) begin
            $error("evicted_tag: expected %0h, actual %0h", want.etag, rsp_if.evicted_tag);
            error_count++;
          end
        end
      end
    end
  end

  task automatic drain_lookups();
    req_if.valid <= 1'b0;
    while (lookup_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_lookup(logic [ADDR_W-1:0] addr, logic [RND_W-1:0] rway,
                             logic typed, logic repl, logic [ETAG_W-1:0] etag);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.address    <= addr;
    req_if.random_way <= rway;
    item_typed        <= typed;
    item_repl         <= repl;
    item_etag         <= etag;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain_lookups();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_DAT_W-1:0] reg_word(logic [3:0] v, int bits);
    logic [CFG_DAT_W-1:0] d;
    d = CFG_DAT_W'($urandom_range(0, 255));
    for (int b = 0; b < bits; b++) d[b] = v[b];
    return d;
  endfunction

  initial begin
    for (int i = 0; i < LINE_CNT; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
      set_count[i]  = '0;
      fifo_ptr[i]   = '0;
    end
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.address    = '0;
    req_if.random_way = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_ORG;
    cfg_if.data       = '0;
    rsp_if.ready      = 1'b0;
    item_typed        = 1'b0;
    item_repl         = 1'b0;
    item_etag         = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_REG)
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      else
        send_lookup(directed_steps[i].addr, directed_steps[i].rway, directed_steps[i].typed,
                    directed_steps[i].repl, directed_steps[i].etag);
    end

    for (int p = 0; p < PHASES; p++) begin
      logic [1:0]        org_v, pol_v;
      logic [3:0]        ll_v, ob_v;
      logic [ADDR_W-1:0] salt, set_base, tag_v, set_v, addr;
      int unsigned       ob, sb, wl, ways, n;
      idle_pct = (p == CALM_PHASE) ? 0 : 36;
      org_v = 2'($urandom_range(0, 3));
      pol_v = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       ll_v = 4'($urandom_range(0, 1));
        1:       ll_v = 4'($urandom_range(10, 15));
        default: ll_v = 4'($urandom_range(2, 5));
      endcase
      if (p == BIG_PHASE) begin
        org_v = ORG_FULL;
        ll_v  = 4'd10;
      end else if (ll_v > 6 && org_v >= ORG_FULL) begin
        org_v = 2'($urandom_range(0, 1));
      end
      ob_v = 4'($urandom_range(0, 15));
      write_reg(REG_ORG, reg_word({2'b0, org_v}, 2));
      write_reg(REG_POLICY, reg_word({2'b0, pol_v}, 2));
      write_reg(REG_LINES, reg_word(ll_v, 4));
      write_reg(REG_OFFSET, reg_word(ob_v, 4));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
      decode_geometry(ob, sb, wl);
      ways     = 1 << wl;
      salt     = $urandom;
      set_base = $urandom;
      n        = (p == BIG_PHASE) ? 12 : 42;
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          addr = $urandom;
        end else begin
          tag_v = salt + $urandom_range(0, ways + ways / 2 + 1);
          set_v = (set_base + $urandom_range(0, 3)) & ((32'd1 << sb) - 1);
          addr  = (tag_v << (ob + sb)) | (set_v << ob) | ($urandom & ((32'd1 << ob) - 1));
        end
        if ($urandom_range(0, 29) == 0) drain_lookups();
        send_lookup(addr, RND_W'($urandom_range(0, 1023)), 1'b0, 1'b0, '0);
      end
    end

    drain_lookups();
    repeat (SETTLE) @(negedge clk_i);
    if (lookup_q.size() != 0) begin
      $error("%0d results never arrived", lookup_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("cache_tag_store_replacement test passed");
    end else begin
      $display("cache_tag_store_replacement test failed");
    end
    $finish;
  end

endmodule
